>>> rtl/gsstok_pkg.sv
package gsstok_pkg;

  // Default build values for the top-level parameters.
  localparam int unsigned MAX_OID_BYTES_DEF = 16;
  localparam int unsigned LENGTH_BITS_DEF   = 32;

  // Port widths.
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CNT_W       = 32;

  // Parser phases.
  localparam int unsigned PH_W = 3;
  localparam logic [PH_W-1:0] PH_TAG    = 3'd0;
  localparam logic [PH_W-1:0] PH_LEN0   = 3'd1;
  localparam logic [PH_W-1:0] PH_LENX   = 3'd2;
  localparam logic [PH_W-1:0] PH_OIDTAG = 3'd3;
  localparam logic [PH_W-1:0] PH_OLEN0  = 3'd4;
  localparam logic [PH_W-1:0] PH_OLENX  = 3'd5;
  localparam logic [PH_W-1:0] PH_OID    = 3'd6;
  localparam logic [PH_W-1:0] PH_PAY    = 3'd7;

  // Token framing bytes.
  localparam logic [7:0] TAG_APP = 8'h60;
  localparam logic [7:0] TAG_OID = 8'h06;

  // Final status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_TOKEN = 3'd1;
  localparam logic [2:0] ST_BAD_LEN   = 3'd2;
  localparam logic [2:0] ST_TRUNC     = 3'd3;
  localparam logic [2:0] ST_TRAILING  = 3'd4;
  localparam logic [2:0] ST_UNK_MECH  = 3'd5;

  // Mechanism identifiers.
  localparam logic [1:0] MECH_NONE = 2'd0;
  localparam logic [1:0] MECH_A    = 2'd1;
  localparam logic [1:0] MECH_B    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_A_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_HI  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A_LO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B_LEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_B_HI  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_B_LO  = 3'd5;

  typedef struct packed {
    logic             payload_valid;
    logic [7:0]       payload_byte;
    logic             done_res;
    logic [2:0]       status;
    logic [1:0]       mech_id;
    logic [CNT_W-1:0] payload_len;
  } res_t;

  // Byte idx of a 16-byte OID held as two words, first byte most significant.
  function automatic logic [7:0] oid_byte(input logic [63:0] hi, input logic [63:0] lo,
                                          input logic [3:0] idx);
    logic [63:0] word;
    logic [5:0]  pos;
    word = idx[3] ? lo : hi;
    pos  = {3'd7 - idx[2:0], 3'b000};
    return word[pos +: 8];
  endfunction

endpackage

>>> rtl/gss_token_header_parser.sv
// Each byte's result is registered into the output register, or into the skid entry while that register
// is stalled. Throughput: one byte per cycle while the skid entry is empty; each byte updates the parser
// state in a single pass. A two-entry output stage lets the slave side take one more byte after the
// master side stalls. Reset (rst_ni low, asynchronous) clears the output stage valid flags, zeroes all
// mechanism registers and returns the parser to its start state; no clearing pass is needed afterward.
module gss_token_header_parser #(
  parameter int unsigned MAX_OID_BYTES = gsstok_pkg::MAX_OID_BYTES_DEF,
  parameter int unsigned LENGTH_BITS   = gsstok_pkg::LENGTH_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Slave side: tdata = data_byte[7:0]; tlast = last_byte.
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [gsstok_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  input  logic                                 s_axis_tlast_i,
  // Master side: tdata = payload_byte[7:0], status[10:8], mech_id[12:11],
  // payload_len[44:13], zero fill[47:45]; tuser = payload_valid; tlast = done_res.
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [gsstok_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  output logic                                 m_axis_tuser_o,
  output logic                                 m_axis_tlast_o,
  // Configuration write port.
  input  logic                                 cfg_we_i,
  input  logic [gsstok_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [gsstok_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import gsstok_pkg::*;

  localparam int unsigned LB     = LENGTH_BITS;
  localparam int unsigned OIDX_W = $clog2(MAX_OID_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Mechanism configuration.
  logic [4:0]  mech_a_len_q, mech_b_len_q;
  logic [63:0] mech_a_hi_q, mech_a_lo_q, mech_b_hi_q, mech_b_lo_q;

  // Parser state.
  logic [PH_W-1:0]   phase_q, phase_d;
  logic [CNT_W-1:0]  byte_cnt_q, byte_cnt_d;
  logic [LB-1:0]     outer_len_q, outer_len_d;
  logic [6:0]        len_left_q, len_left_d;
  logic [7:0]        hdr_bytes_q, hdr_bytes_d;
  logic [LB-1:0]     oid_len_q, oid_len_d;
  logic [OIDX_W-1:0] oid_idx_q, oid_idx_d;
  logic [LB-1:0]     oid_left_q, oid_left_d;
  logic [1:0]        match_q, match_d;
  logic              halted_q, halted_d;
  logic [CNT_W-1:0]  pay_cnt_q, pay_cnt_d;

  // Output stage: main register plus one skid entry.
  res_t out_q, skid_q, res;
  logic out_valid_q, skid_valid_q;

  logic       in_xfer, out_xfer;
  logic [7:0] in_byte;
  logic       in_last;

  assign in_byte  = s_axis_tdata_i[7:0];
  assign in_last  = s_axis_tlast_i;
  assign s_axis_tready_o = !skid_valid_q;
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes must only happen while the parser is idle; the block does not enforce it.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mech_a_len_q <= '0;
      mech_a_hi_q  <= '0;
      mech_a_lo_q  <= '0;
      mech_b_len_q <= '0;
      mech_b_hi_q  <= '0;
      mech_b_lo_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_A_LEN: mech_a_len_q <= cfg_data_i[4:0];
        REG_A_HI:  mech_a_hi_q  <= cfg_data_i;
        REG_A_LO:  mech_a_lo_q  <= cfg_data_i;
        REG_B_LEN: mech_b_len_q <= cfg_data_i[4:0];
        REG_B_HI:  mech_b_hi_q  <= cfg_data_i;
        REG_B_LO:  mech_b_lo_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Per-byte parser step. Everything below is one combinational pass from the
  // current state and the incoming byte to the next state and the result.
  // ---------------------------------------------------------------------------
  logic          len_ovf;
  logic [LB-1:0] len_shift;
  logic [LB-1:0] len_acc;
  logic          start_oid;
  logic [3:0]    oid_sel;
  logic [7:0]    ref_a, ref_b;

  // A long-form length byte overflows when the accumulator already has any of
  // its top eight bits set.
  assign len_acc   = (phase_q == PH_OLENX) ? oid_len_q : outer_len_q;
  assign len_ovf   = (len_acc[LB-1 -: 8] != 8'd0);
  assign len_shift = {len_acc[LB-9:0], in_byte};

  assign oid_sel = 4'(oid_idx_q);
  assign ref_a   = oid_byte(mech_a_hi_q, mech_a_lo_q, oid_sel);
  assign ref_b   = oid_byte(mech_b_hi_q, mech_b_lo_q, oid_sel);

  always_comb begin
    phase_d     = phase_q;
    byte_cnt_d  = (byte_cnt_q != CNT_MAX) ? byte_cnt_q + 1'b1 : byte_cnt_q;
    outer_len_d = outer_len_q;
    len_left_d  = len_left_q;
    hdr_bytes_d = hdr_bytes_q;
    oid_len_d   = oid_len_q;
    oid_idx_d   = oid_idx_q;
    oid_left_d  = oid_left_q;
    match_d     = match_q;
    halted_d    = halted_q;
    pay_cnt_d   = pay_cnt_q;
    start_oid   = 1'b0;

    if (!halted_q) begin
      case (phase_q)
        PH_TAG: begin
          if (in_byte != TAG_APP) halted_d = 1'b1;
          else phase_d = PH_LEN0;
        end
        PH_LEN0: begin
          if (!in_byte[7]) begin
            outer_len_d = LB'(in_byte);
            hdr_bytes_d = 8'd2;
            phase_d     = PH_OIDTAG;
          end else begin
            len_left_d  = in_byte[6:0];
            outer_len_d = '0;
            hdr_bytes_d = 8'd2 + {1'b0, in_byte[6:0]};
            phase_d     = (in_byte[6:0] == 7'd0) ? PH_OIDTAG : PH_LENX;
          end
        end
        PH_LENX: begin
          if (len_ovf) begin
            halted_d = 1'b1;
          end else begin
            outer_len_d = len_shift;
            len_left_d  = len_left_q - 7'd1;
            if (len_left_q == 7'd1) phase_d = PH_OIDTAG;
          end
        end
        PH_OIDTAG: begin
          if (in_byte != TAG_OID) halted_d = 1'b1;
          else phase_d = PH_OLEN0;
        end
        PH_OLEN0: begin
          if (!in_byte[7]) begin
            oid_len_d = LB'(in_byte);
            start_oid = 1'b1;
          end else begin
            len_left_d = in_byte[6:0];
            oid_len_d  = '0;
            if (in_byte[6:0] == 7'd0) start_oid = 1'b1;
            else phase_d = PH_OLENX;
          end
        end
        PH_OLENX: begin
          if (len_ovf) begin
            halted_d = 1'b1;
          end else begin
            oid_len_d  = len_shift;
            len_left_d = len_left_q - 7'd1;
            if (len_left_q == 7'd1) start_oid = 1'b1;
          end
        end
        PH_OID: begin
          if (oid_idx_q < OIDX_W'(MAX_OID_BYTES)) begin
            if (in_byte != ref_a) match_d[0] = 1'b0;
            if (in_byte != ref_b) match_d[1] = 1'b0;
            oid_idx_d = oid_idx_q + 1'b1;
          end else begin
            match_d = 2'b00;
          end
          oid_left_d = oid_left_q - 1'b1;
          if (oid_left_q == LB'(1)) phase_d = PH_PAY;
        end
        default: begin
          if (pay_cnt_q != CNT_MAX) pay_cnt_d = pay_cnt_q + 1'b1;
        end
      endcase
    end

    // Once the OID length is known, arm the candidates whose configured length
    // is usable and equal to it.
    if (start_oid) begin
      match_d[0] = (mech_a_len_q != 5'd0) && (mech_a_len_q <= 5'(MAX_OID_BYTES)) &&
                   (LB'(mech_a_len_q) == oid_len_d);
      match_d[1] = (mech_b_len_q != 5'd0) && (mech_b_len_q <= 5'(MAX_OID_BYTES)) &&
                   (LB'(mech_b_len_q) == oid_len_d);
      oid_idx_d  = '0;
      oid_left_d = oid_len_d;
      phase_d    = (oid_len_d == '0) ? PH_PAY : PH_OID;
    end
  end

  // ---------------------------------------------------------------------------
  // Final status, taken from the state after this byte. The checks run in a
  // fixed priority: framing and size, outer length, OID tag, length agreement,
  // OID length, then mechanism lookup.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] rest;
  logic [CNT_W-1:0] outer_len_ext;
  logic [2:0]       final_st;

  assign rest          = byte_cnt_d - CNT_W'(hdr_bytes_d);
  assign outer_len_ext = CNT_W'(outer_len_d);

  always_comb begin
    if (byte_cnt_d < CNT_W'(4) || phase_d == PH_TAG) begin
      final_st = ST_NOT_TOKEN;
    end else if (phase_d == PH_LEN0 || phase_d == PH_LENX) begin
      final_st = ST_BAD_LEN;
    end else if (outer_len_ext > rest) begin
      final_st = ST_BAD_LEN;
    end else if (rest < CNT_W'(2) || phase_d == PH_OIDTAG) begin
      final_st = ST_NOT_TOKEN;
    end else if (rest != outer_len_ext) begin
      final_st = (rest < outer_len_ext) ? ST_TRUNC : ST_TRAILING;
    end else if (phase_d != PH_PAY) begin
      final_st = ST_BAD_LEN;
    end else begin
      final_st = (match_d != 2'b00) ? ST_OK : ST_UNK_MECH;
    end
  end

  always_comb begin
    res.payload_valid = !halted_q && (phase_q == PH_PAY);
    res.payload_byte  = in_byte;
    res.done_res      = in_last;
    res.status        = in_last ? final_st : ST_OK;
    res.mech_id       = MECH_NONE;
    if (in_last && final_st == ST_OK) res.mech_id = match_d[0] ? MECH_A : MECH_B;
    res.payload_len   = pay_cnt_d;
  end

  // ---------------------------------------------------------------------------
  // State registers. The last byte of a token returns the parser to its reset
  // state; the mechanism registers are kept.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_TAG;
      byte_cnt_q  <= '0;
      outer_len_q <= '0;
      len_left_q  <= '0;
      hdr_bytes_q <= '0;
      oid_len_q   <= '0;
      oid_idx_q   <= '0;
      oid_left_q  <= '0;
      match_q     <= 2'b11;
      halted_q    <= 1'b0;
      pay_cnt_q   <= '0;
    end else if (in_xfer) begin
      if (in_last) begin
        phase_q     <= PH_TAG;
        byte_cnt_q  <= '0;
        outer_len_q <= '0;
        len_left_q  <= '0;
        hdr_bytes_q <= '0;
        oid_len_q   <= '0;
        oid_idx_q   <= '0;
        oid_left_q  <= '0;
        match_q     <= 2'b11;
        halted_q    <= 1'b0;
        pay_cnt_q   <= '0;
      end else begin
        phase_q     <= phase_d;
        byte_cnt_q  <= byte_cnt_d;
        outer_len_q <= outer_len_d;
        len_left_q  <= len_left_d;
        hdr_bytes_q <= hdr_bytes_d;
        oid_len_q   <= oid_len_d;
        oid_idx_q   <= oid_idx_d;
        oid_left_q  <= oid_left_d;
        match_q     <= match_d;
        halted_q    <= halted_d;
        pay_cnt_q   <= pay_cnt_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage. The skid entry catches a result that arrives while the main
  // register is stalled; the slave side stops only while the skid entry is full.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_xfer;
      end
    end else if (in_xfer) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready_i) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (in_xfer) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.payload_valid;
  assign m_axis_tlast_o  = out_q.done_res;
  assign m_axis_tdata_o  = {3'b000, out_q.payload_len, out_q.mech_id, out_q.status,
                            out_q.payload_byte};

`ifndef SYNTHESIS
  // The skid entry is only ever filled behind a stalled main register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a result while the output register is empty");

  // The last byte of a token always leaves the parser in its reset state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_last) |=> (phase_q == PH_TAG && !halted_q && byte_cnt_q == '0 &&
                              pay_cnt_q == '0 && match_q == 2'b11))
    else $error("parser not cleared after the last byte of a token");

  // A successful token always names a mechanism.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.done_res && out_q.status == ST_OK) |->
      (out_q.mech_id == MECH_A || out_q.mech_id == MECH_B))
    else $error("ok status without a mechanism");

  // Status and mechanism are only reported on the last byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.done_res) |-> (out_q.status == ST_OK && out_q.mech_id == MECH_NONE))
    else $error("status reported before the last byte");

  // The OID byte index never runs past the compare window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    oid_idx_q <= OIDX_W'(MAX_OID_BYTES))
    else $error("OID index beyond the compare window");
`endif

endmodule
